FILE: hdl/tdrt_pkg.sv
// Package for the triggered delay relay timer.
// Holds phase codes, register indexes and reset values; no dependencies.
package tdrt_pkg;

    localparam int TIME_W  = 32;
    localparam int PHASE_W = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [PHASE_W-1:0] PH_IDLE   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_TIMING = 2'd1;
    localparam logic [PHASE_W-1:0] PH_RELAY  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DURATION  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_OFF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_MODE  = 2'd2;

    localparam logic OFF_BY_DELAY = 1'b0;
    localparam logic OFF_BY_CTRL  = 1'b1;

    localparam logic [TIME_W-1:0] MIN_TIME_MS       = 32'd100;
    localparam logic [TIME_W-1:0] DURATION_RESET_MS = 32'd5000;
    localparam logic [TIME_W-1:0] DELAY_RESET_MS    = 32'd2000;

    function automatic logic [TIME_W-1:0] at_least_min(input logic [TIME_W-1:0] v);
        return (v < MIN_TIME_MS) ? MIN_TIME_MS : v;
    endfunction

endpackage

FILE: hdl/triggered_delay_relay_timer.sv
// Triggered on-delay relay timer: input register, one step of logic, result register.
// Depends on tdrt_pkg.
// The step between the registers is a few 32-bit subtracts and compares.
// Throughput: one beat per cycle unless a low out_ready stalls the result.
// The timer state updates when the input register moves into the result register.
// Reset: asynchronous, active low; phase idle, relay off, starts zero, registers
// at their reset values, both pipeline registers empty.
module triggered_delay_relay_timer
    import tdrt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TIME_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 enabled,
    input  logic                 pulse_seen,
    input  logic [TIME_W-1:0]    pulse_time,
    input  logic                 ctrl_seen,
    input  logic [TIME_W-1:0]    ctrl_time,
    input  logic [TIME_W-1:0]    now_ms,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 relay_drive,
    output logic                 running,
    output logic [TIME_W-1:0]    elapsed_ms,
    output logic [PHASE_W-1:0]   phase
);

    logic [TIME_W-1:0]  duration_reg;
    logic [TIME_W-1:0]  delay_off_reg;
    logic               off_mode_reg;

    logic [PHASE_W-1:0] phase_reg;
    logic [TIME_W-1:0]  timing_start_reg;
    logic [TIME_W-1:0]  relay_start_reg;
    logic               relay_level_reg;

    logic               in_valid_reg;
    logic               en_reg;
    logic               pulse_reg;
    logic [TIME_W-1:0]  pulse_time_reg;
    logic               ctrl_reg;
    logic [TIME_W-1:0]  ctrl_time_reg;
    logic [TIME_W-1:0]  now_reg;

    logic               out_valid_reg;
    logic               relay_drive_reg;
    logic               running_reg;
    logic [TIME_W-1:0]  elapsed_reg;
    logic [PHASE_W-1:0] phase_out_reg;

    logic [PHASE_W-1:0] phase_next;
    logic [TIME_W-1:0]  timing_start_next;
    logic [TIME_W-1:0]  relay_start_next;
    logic               relay_level_next;
    logic               stopped;
    logic               advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        phase_next        = (phase_reg == PH_TIMING || phase_reg == PH_RELAY) ?
                            phase_reg : PH_IDLE;
        timing_start_next = timing_start_reg;
        relay_start_next  = relay_start_reg;
        relay_level_next  = relay_level_reg;
        stopped           = 1'b0;
        if (!en_reg)
        begin
            phase_next       = PH_IDLE;
            relay_level_next = 1'b0;
        end
        else
        begin
            if (pulse_reg)
            begin
                phase_next        = PH_TIMING;
                timing_start_next = pulse_time_reg;
                relay_level_next  = 1'b0;
            end
            stopped = (off_mode_reg == OFF_BY_CTRL) && ctrl_reg &&
                      (phase_next != PH_IDLE) && (ctrl_time_reg >= timing_start_next);
            if (stopped)
            begin
                phase_next       = PH_IDLE;
                relay_level_next = 1'b0;
            end
            else
            begin
                if (phase_next == PH_TIMING &&
                    (now_reg - timing_start_next) >= duration_reg)
                begin
                    phase_next       = PH_RELAY;
                    relay_start_next = now_reg;
                    relay_level_next = 1'b1;
                end
                if (phase_next == PH_RELAY && off_mode_reg == OFF_BY_DELAY &&
                    (now_reg - relay_start_next) >= delay_off_reg)
                begin
                    phase_next       = PH_IDLE;
                    relay_level_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duration_reg  <= DURATION_RESET_MS;
            delay_off_reg <= DELAY_RESET_MS;
            off_mode_reg  <= OFF_BY_DELAY;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DURATION:  duration_reg  <= at_least_min(cfg_data);
                CFG_DELAY_OFF: delay_off_reg <= at_least_min(cfg_data);
                CFG_OFF_MODE:  off_mode_reg  <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            timing_start_reg <= '0;
            relay_start_reg  <= '0;
            relay_level_reg  <= 1'b0;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                phase_reg        <= phase_next;
                timing_start_reg <= timing_start_next;
                relay_start_reg  <= relay_start_next;
                relay_level_reg  <= relay_level_next;
                out_valid_reg    <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            en_reg         <= enabled;
            pulse_reg      <= pulse_seen;
            pulse_time_reg <= pulse_time;
            ctrl_reg       <= ctrl_seen;
            ctrl_time_reg  <= ctrl_time;
            now_reg        <= now_ms;
        end
        if (advance)
        begin
            relay_drive_reg <= relay_level_next;
            running_reg     <= (phase_next == PH_TIMING);
            elapsed_reg     <= (phase_next == PH_TIMING) ?
                               (now_reg - timing_start_next) : '0;
            phase_out_reg   <= phase_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign relay_drive = relay_drive_reg;
    assign running     = running_reg;
    assign elapsed_ms  = elapsed_reg;
    assign phase       = phase_out_reg;

endmodule

FILE: hdl/tdrt_checker.sv
// Port-level checks for the triggered delay relay timer, with its bind.
// Depends on tdrt_pkg and triggered_delay_relay_timer.
module tdrt_checker
    import tdrt_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic               relay_drive,
    input logic               running,
    input logic [TIME_W-1:0]  elapsed_ms,
    input logic [PHASE_W-1:0] phase
);

    property p_hold;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(phase) && $stable(elapsed_ms);
    endproperty
    a_hold: assert property (p_hold) else $error("result beat changed while stalled");

    property p_running;
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> running == (phase == PH_TIMING);
    endproperty
    a_running: assert property (p_running) else $error("running disagrees with phase");

    property p_elapsed;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !running |-> elapsed_ms == '0;
    endproperty
    a_elapsed: assert property (p_elapsed) else $error("elapsed nonzero outside timing");

    property p_relay;
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> relay_drive == (phase == PH_RELAY);
    endproperty
    a_relay: assert property (p_relay) else $error("relay level disagrees with phase");

endmodule

bind triggered_delay_relay_timer tdrt_checker u_tdrt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .relay_drive (relay_drive),
    .running     (running),
    .elapsed_ms  (elapsed_ms),
    .phase       (phase)
);
